// ===== rtl/block_cache_lru_tag_store_assert.svh =====
// Assertion macros for the block cache LRU tag store.
// Plain text macros only; no other file is needed.
`ifndef BLOCK_CACHE_LRU_TAG_STORE_ASSERT_SVH
`define BLOCK_CACHE_LRU_TAG_STORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define BCLTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tag store assertion failed");

// Next-cycle implication under an active-low reset.
`define BCLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tag store assertion failed");

`endif

// ===== rtl/bclts_pkg.sv =====
// Shared widths and command codes of the block cache LRU tag store.
// Used by the top level; depends on nothing.
package bclts_pkg;

	localparam int ID_W   = 31;
	localparam int CMD_W  = 2;
	localparam int SLOT_W = 4;
	localparam int CFG_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

endpackage

// ===== rtl/block_cache_lru_tag_store.sv =====
// Top level of the block cache LRU tag store: entry memory, scan sequencer, response register.
// Depends on bclts_pkg and on the assertion macros in block_cache_lru_tag_store_assert.svh.
//
// A new item is accepted only once the last is finished. With n as slots_in_use clamped to
// 1..SLOTS, the single read port of the entry memory scans one entry per cycle for match,
// victim and, on reads, aging; ST_LAST retires the last entry read, and ST_FIN writes the
// accessed entry on reads and loads the response register once it is free. Valid bits sit in
// flip-flops that reset clears, so the block is ready right after reset with no clearing pass.
`include "block_cache_lru_tag_store_assert.svh"

module block_cache_lru_tag_store #(
	parameter int SLOTS    = 16,
	parameter int AGE_WRAP = 1000000000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bclts_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [bclts_pkg::CMD_W-1:0]     cmd,
	input  logic [bclts_pkg::ID_W-1:0]      block_id,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            hit,
	output logic [bclts_pkg::SLOT_W-1:0]    slot,
	output logic                            fill_needed
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW = ($clog2(SLOTS + 1) > bclts_pkg::CFG_W) ? $clog2(SLOTS + 1)
		: bclts_pkg::CFG_W;
	localparam int AW = $clog2(AGE_WRAP + 1);
	localparam int EW = bclts_pkg::ID_W + AW;
	localparam logic [NW-1:0] SLOTS_N = NW'(SLOTS);
	localparam logic [AW-1:0] WRAP_A = AW'(AGE_WRAP);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_FIN} state_t;

	state_t                          state_q;
	logic [bclts_pkg::CFG_W-1:0]     slots_in_use_q;
	logic [SLOTS-1:0]                valid_q;
	logic                            rvalid_s1;
	logic [SW-1:0]                   ridx_s1;
	logic [EW-1:0]                   rdata_s1;
	logic [EW-1:0]                   entry_mem_q [SLOTS];
	logic [SW-1:0]                   idx_q;
	logic [bclts_pkg::CMD_W-1:0]     cmd_q;
	logic [bclts_pkg::ID_W-1:0]      id_q;
	logic                            match_q;
	logic [SW-1:0]                   match_idx_q;
	logic                            inv_found_q;
	logic [SW-1:0]                   inv_idx_q;
	logic                            max_found_q;
	logic [SW-1:0]                   max_idx_q;
	logic [AW-1:0]                   max_age_q;
	logic                            rsp_valid_q;
	logic                            hit_q;
	logic [bclts_pkg::SLOT_W-1:0]    slot_q;
	logic                            fill_q;

	logic [NW-1:0]                   cfg_ext;
	logic [NW-1:0]                   n_active;
	logic [SW-1:0]                   last_idx;
	logic                            req_acc;
	logic                            fin_fire;
	logic [bclts_pkg::ID_W-1:0]      rd_blk;
	logic [AW-1:0]                   rd_age;
	logic                            rd_v;
	logic [AW-1:0]                   age_next;
	logic [SW-1:0]                   victim;
	logic [SW-1:0]                   acc_slot;
	logic                            mem_we;
	logic [SW-1:0]                   mem_waddr;
	logic [EW-1:0]                   mem_wdata;
	logic                            mem_re;
	logic [SW-1:0]                   mem_raddr;

	assign cfg_ready   = 1'b1;
	assign req_stall   = (state_q != ST_IDLE);
	assign req_acc     = req_valid && !req_stall;
	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign fill_needed = fill_q;

	always_comb begin
		cfg_ext = NW'(slots_in_use_q);
		if (cfg_ext == '0) begin
			n_active = NW'(1);
		end else if (cfg_ext > SLOTS_N) begin
			n_active = SLOTS_N;
		end else begin
			n_active = cfg_ext;
		end
		last_idx = SW'(n_active - NW'(1));
	end

	assign rd_blk   = rdata_s1[EW-1:AW];
	assign rd_age   = rdata_s1[AW-1:0];
	assign rd_v     = valid_q[ridx_s1];
	assign age_next = (rd_age >= WRAP_A) ? AW'(1) : rd_age + AW'(1);
	assign victim   = inv_found_q ? inv_idx_q : max_idx_q;
	assign acc_slot = match_q ? match_idx_q : victim;
	assign fin_fire = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	assign mem_re    = req_acc || (state_q == ST_SCAN);
	assign mem_raddr = req_acc ? '0 : idx_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ridx_s1;
		mem_wdata = {rd_blk, age_next};
		if (rvalid_s1 && cmd_q == bclts_pkg::CMD_READ && rd_v) begin
			mem_we = 1'b1;
		end
		if (fin_fire && cmd_q == bclts_pkg::CMD_READ) begin
			mem_we    = 1'b1;
			mem_waddr = acc_slot;
			mem_wdata = {id_q, AW'(0)};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= entry_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q       <= cmd;
			id_q        <= block_id;
			ridx_s1     <= '0;
			idx_q       <= SW'(1);
			match_q     <= 1'b0;
			inv_found_q <= 1'b0;
			max_found_q <= 1'b0;
		end else begin
			if (state_q == ST_SCAN) begin
				ridx_s1 <= idx_q;
				idx_q   <= idx_q + SW'(1);
			end
			if (rvalid_s1) begin
				if (rd_v && rd_blk == id_q && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= ridx_s1;
				end
				if (!rd_v && !inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_idx_q   <= ridx_s1;
				end
				if (rd_v && (!max_found_q || rd_age > max_age_q)) begin
					max_found_q <= 1'b1;
					max_idx_q   <= ridx_s1;
					max_age_q   <= rd_age;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= bclts_pkg::CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			slots_in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rvalid_s1   <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			slot_q      <= '0;
			fill_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						rvalid_s1 <= 1'b1;
						state_q   <= (last_idx == '0) ? ST_LAST : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rvalid_s1 <= 1'b1;
					if (idx_q == last_idx) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					rvalid_s1 <= 1'b0;
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_fire) begin
						rsp_valid_q <= 1'b1;
						fill_q      <= 1'b0;
						case (cmd_q)
							bclts_pkg::CMD_READ: begin
								hit_q             <= match_q;
								slot_q            <= bclts_pkg::SLOT_W'(acc_slot);
								fill_q            <= !match_q;
								valid_q[acc_slot] <= 1'b1;
							end
							bclts_pkg::CMD_WRITE: begin
								hit_q  <= match_q;
								slot_q <= match_q ? bclts_pkg::SLOT_W'(match_idx_q) : '0;
							end
							bclts_pkg::CMD_DELETE: begin
								hit_q  <= match_q;
								slot_q <= match_q ? bclts_pkg::SLOT_W'(match_idx_q) : '0;
								if (match_q) begin
									valid_q[match_idx_q] <= 1'b0;
								end
							end
							default: begin
								hit_q  <= 1'b0;
								slot_q <= '0;
							end
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BCLTS_ASSERT_IMPLIES(a_no_rmw_clash, clk, arst_n, (mem_we && state_q == ST_SCAN), (mem_waddr != idx_q))
	`BCLTS_ASSERT_NEXT(a_accept_reads_first, clk, arst_n, req_acc, (rvalid_s1 && ridx_s1 == '0))
	`BCLTS_ASSERT_IMPLIES(a_no_read_in_flight, clk, arst_n, (state_q == ST_FIN || state_q == ST_IDLE), !rvalid_s1)

endmodule

// ===== sim/tb.sv =====
// Testbench for block_cache_lru_tag_store: a directed table, then random lookups in phases.
// Results are checked against a predictor of the tag, valid and age store kept here.
// Depends on bclts_pkg and the RTL of the tag store.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int AGE_WRAP = 1000000000;
	localparam logic [bclts_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 39;
	localparam int POOL_SIZE = 24;
	localparam int N_ROWS = 26;

	typedef struct packed {
		logic hit;
		logic [bclts_pkg::SLOT_W-1:0] slot;
		logic fill_needed;
	} lookup_result_t;

	typedef struct packed {
		logic [bclts_pkg::CMD_W-1:0] cmd;
		logic [bclts_pkg::ID_W-1:0] block_id;
		bit typed;
		lookup_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bclts_pkg::CFG_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [bclts_pkg::CMD_W-1:0] cmd = bclts_pkg::CMD_READ;
	logic [bclts_pkg::ID_W-1:0] block_id = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic hit;
	logic [bclts_pkg::SLOT_W-1:0] slot;
	logic fill_needed;

	bit tag_valid [SLOTS];
	bit [bclts_pkg::ID_W-1:0] tag_block [SLOTS];
	bit [29:0] tag_age [SLOTS];
	logic [bclts_pkg::CFG_W-1:0] slots_cfg = 5'd16;

	lookup_result_t pending_lookups [$];
	int error_count = 0;
	int quiet_cycles = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	logic [bclts_pkg::ID_W-1:0] id_pool [POOL_SIZE];
	logic [bclts_pkg::CFG_W-1:0] cfg_plan [PHASES];

	stim_row_t directed_rows [N_ROWS] = '{
		'{bclts_pkg::CMD_READ,   31'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b1}},
		'{bclts_pkg::CMD_READ,   31'h7FFF_FFFF, 1'b1, '{1'b0, 4'd1, 1'b1}},
		'{bclts_pkg::CMD_READ,   31'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_WRITE,  31'h7FFF_FFFF, 1'b1, '{1'b1, 4'd1, 1'b0}},
		'{bclts_pkg::CMD_WRITE,  31'h2AAA_AAAA, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_DELETE, 31'h5555_5555, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{CMD_UNUSED,            31'h7FFF_FFFF, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_DELETE, 31'h0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_WRITE,  31'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_READ,   31'h5555_5555, 1'b1, '{1'b0, 4'd0, 1'b1}},
		'{bclts_pkg::CMD_READ,   31'h2AAA_AAAA, 1'b1, '{1'b0, 4'd2, 1'b1}},
		'{CMD_UNUSED,            31'h0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0}},
		'{bclts_pkg::CMD_READ,   31'd100, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd101, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd102, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd103, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd104, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd105, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd106, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd107, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd108, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd109, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd110, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd111, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd112, 1'b0, '0},
		'{bclts_pkg::CMD_READ,   31'd200, 1'b0, '0}
	};

	block_cache_lru_tag_store #(
		.SLOTS(SLOTS),
		.AGE_WRAP(AGE_WRAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.block_id(block_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit(hit),
		.slot(slot),
		.fill_needed(fill_needed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int active_entries();
		int n;
		n = int'(slots_cfg);
		if (n < 1) n = 1;
		if (n > SLOTS) n = SLOTS;
		return n;
	endfunction

	function automatic lookup_result_t predict_lookup(input logic [bclts_pkg::CMD_W-1:0] c,
			input logic [bclts_pkg::ID_W-1:0] id);
		lookup_result_t res;
		int n;
		int found;
		int victim;
		res = '0;
		n = active_entries();
		found = -1;
		for (int i = 0; i < n; i++) begin
			if (found < 0 && tag_valid[i] && tag_block[i] == id) found = i;
		end
		if (c == bclts_pkg::CMD_READ) begin
			if (found >= 0) begin
				victim = found;
				res.hit = 1'b1;
			end else begin
				victim = -1;
				for (int i = 0; i < n; i++) begin
					if (victim < 0 && !tag_valid[i]) victim = i;
				end
				if (victim < 0) begin
					victim = 0;
					for (int i = 1; i < n; i++) begin
						if (tag_age[i] > tag_age[victim]) victim = i;
					end
				end
				tag_valid[victim] = 1'b1;
				tag_block[victim] = id;
				res.fill_needed = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				if (tag_valid[i]) tag_age[i] = 30'((32'(tag_age[i]) % AGE_WRAP) + 1);
			end
			tag_age[victim] = '0;
			res.slot = bclts_pkg::SLOT_W'(victim);
		end else if (c == bclts_pkg::CMD_WRITE) begin
			if (found >= 0) begin
				res.hit = 1'b1;
				res.slot = bclts_pkg::SLOT_W'(found);
			end
		end else if (c == bclts_pkg::CMD_DELETE) begin
			if (found >= 0) begin
				res.hit = 1'b1;
				res.slot = bclts_pkg::SLOT_W'(found);
				tag_valid[found] = 1'b0;
			end
		end
		return res;
	endfunction

	task automatic send_item(input logic [bclts_pkg::CMD_W-1:0] c,
			input logic [bclts_pkg::ID_W-1:0] id,
			input bit typed, input lookup_result_t typed_res);
		lookup_result_t predicted;
		req_valid <= 1'b1;
		cmd <= c;
		block_id <= id;
		do @(posedge clk); while (req_stall);
		predicted = predict_lookup(c, id);
		pending_lookups.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_lookups.size() == 0) begin
				$error("result with no item outstanding");
				error_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					error_count++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					error_count++;
				end
				if (fill_needed !== want.fill_needed) begin
					$error("fill_needed: expected %0d, got %0d", want.fill_needed,
						fill_needed);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int send_pct;
		int count;
		int pool_n;
		logic [bclts_pkg::CMD_W-1:0] c;
		logic [bclts_pkg::ID_W-1:0] id;
		int r;

		id_pool[0] = 31'h0000_0000;
		id_pool[1] = 31'h7FFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 31'($urandom());
		cfg_plan = '{5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd16, 5'd2, 5'd8, 5'd0, 5'd5};
		cfg_plan[8] = 5'($urandom_range(0, 31));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_ROWS; k++) begin
			send_item(directed_rows[k].cmd, directed_rows[k].block_id,
				directed_rows[k].typed, directed_rows[k].res);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_plan[p];
			do @(posedge clk); while (!cfg_ready);
			slots_cfg = cfg_plan[p];
			cfg_valid <= 1'b0;

			case (p % 4)
				0: begin send_pct = 0; stall_pct <= 0; end
				1: begin send_pct = 51; stall_pct <= 0; end
				2: begin send_pct = 0; stall_pct <= 51; end
				default: begin send_pct = 34; stall_pct <= 34; end
			endcase
			if (p == 2) hold_go <= 1'b1;
			pool_n = active_entries() + $urandom_range(1, 4);
			if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;

			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				while ($urandom_range(0, 99) < send_pct) begin
					req_valid <= 1'b0;
					@(posedge clk);
				end
				r = $urandom_range(0, 99);
				if (r < 55) c = bclts_pkg::CMD_READ;
				else if (r < 72) c = bclts_pkg::CMD_WRITE;
				else if (r < 92) c = bclts_pkg::CMD_DELETE;
				else c = CMD_UNUSED;
				if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, pool_n - 1)];
				else id = 31'($urandom());
				send_item(c, id, 1'b0, '0);
				if (c != CMD_UNUSED) count++;
				if (p == 5 && count == 20) drain();
			end
			drain();
		end

		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== block_cache_lru_tag_store.f =====
+incdir+rtl
rtl/bclts_pkg.sv
rtl/block_cache_lru_tag_store.sv
sim/tb.sv
